// ===== sv/css_pkg.sv =====
// shared types and constants for the comment-skipping token scanner
package css_pkg;

  // comment tracking modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_STAR   = 3'd3,
    MODE_LINE   = 3'd4
  } mode_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_index_t;

  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // per-region scan state
  typedef struct packed {
    mode_t      mode;
    logic [3:0] count;
    logic       found;
    logic       content;
    logic       stopped;
  } scan_t;

  localparam scan_t SCAN_CLEAR = '{mode: MODE_NORMAL, count: 4'd0, found: 1'b0,
                                   content: 1'b0, stopped: 1'b0};

endpackage

// ===== sv/css_if.sv =====
// stream interfaces for the scanner's byte input and result output
interface css_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       region_end;

  modport source (output valid, output char_in, output region_end, input ready);
  modport sink   (input valid, input char_in, input region_end, output ready);
endinterface

interface css_out_if;
  logic valid;
  logic ready;
  logic pattern_found;
  logic has_content;

  modport source (output valid, output pattern_found, output has_content, input ready);
  modport sink   (input valid, input pattern_found, input has_content, output ready);
endinterface

// ===== sv/comment_skipping_token_scanner_core.sv =====
// top level of the comment-skipping token scanner
// path: a byte is loaded into the input register; a region's result is then loaded into
//   the output register, which shows it on the output
// throughput: one byte per cycle but for the wait below, set by the scan loop in css_step
// a byte waits in the input register only when it ends a region and the output register
//   still holds an untaken result
// reset: synchronous active-low rst_n empties both registers, clears the scan state and
//   sets pattern bytes to zero and pattern length to one
module comment_skipping_token_scanner_core #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  css_in_if.sink                           in_ch,
  css_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  css_pkg::cfg_index_t              cfg_index,
  input  logic [css_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers: only bytes that a clamped length can reach are kept
  logic [7:0] pat_r [MAX_PATTERN];
  logic [3:0] len_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       s1_adv;

  // scan state carried from byte to byte
  css_pkg::scan_t scan_r;
  css_pkg::scan_t scan_nxt;

  // output register
  logic out_valid_r;
  logic found_r;
  logic content_r;
  logic step_found;
  logic step_content;

  // a region-ending byte needs room in the output register, others always move on
  assign s1_adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 4'd1;
      for (int i = 0; i < MAX_PATTERN; i++) pat_r[i] <= 8'h00;
    end else if (cfg_we) begin
      unique case (cfg_index)
        css_pkg::CFG_PATTERN_BYTES: begin
          for (int i = 0; i < MAX_PATTERN; i++) pat_r[i] <= cfg_wdata[8*i +: 8];
        end
        css_pkg::CFG_PATTERN_LENGTH: len_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // input register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_in;
      s1_last_r <= in_ch.region_end;
    end
  end

  css_step #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_step (
    .scan_cur       (scan_r),
    .char_in        (s1_char_r),
    .region_end     (s1_last_r),
    .pattern        (pat_r),
    .pattern_length (len_r),
    .scan_nxt       (scan_nxt),
    .pattern_found  (step_found),
    .has_content    (step_content)
  );

  // scan state advances once per byte leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= css_pkg::SCAN_CLEAR;
    end else if (s1_adv) begin
      scan_r <= scan_nxt;
    end
  end

  // result register, loaded on the region's last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      found_r   <= step_found;
      content_r <= step_content;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pattern_found = found_r;
  assign out_ch.has_content   = content_r;

  // match count never reaches the pattern storage depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.count < 4'(MAX_PATTERN))
    else $error("match count out of range");

  // region end leaves a clean scan state
  a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> scan_r == css_pkg::SCAN_CLEAR)
    else $error("scan state not cleared after region end");

  // once stopped, flags stay put until the region ends
  a_stopped_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_last_r && scan_r.stopped |=>
      scan_r.stopped && scan_r.found == $past(scan_r.found) &&
      scan_r.content == $past(scan_r.content))
    else $error("flags changed after stop");

  // a new result appears only after a region-ending byte moved on
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result without region end");

endmodule

// ===== sv/css_step.sv =====
// one-byte scan step: comment stripping, pattern match and content check
module css_step #(
  parameter int MAX_PATTERN = 8
) (
  input  css_pkg::scan_t scan_cur,
  input  logic [7:0]     char_in,
  input  logic           region_end,
  input  logic [7:0]     pattern [MAX_PATTERN],
  input  logic [3:0]     pattern_length,
  output css_pkg::scan_t scan_nxt,
  output logic           pattern_found,
  output logic           has_content
);

  localparam int         CntW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [3:0] MaxLen = 4'(MAX_PATTERN);

  logic [3:0]     len_eff;
  css_pkg::scan_t s;

  assign len_eff = (pattern_length > MaxLen) ? MaxLen : pattern_length;

  // one surviving byte into the match and content trackers
  function automatic css_pkg::scan_t take(css_pkg::scan_t st, logic [7:0] c);
    css_pkg::scan_t n;
    logic [3:0]     nc;
    logic [7:0]     want;
    n    = st;
    nc   = st.count + 4'd1;
    want = pattern[st.count[CntW-1:0]];
    if (!st.stopped) begin
      if (c == css_pkg::CHAR_NUL) begin
        n.stopped = 1'b1;
      end else begin
        if (c != css_pkg::CHAR_SPACE && c != css_pkg::CHAR_TAB &&
            c != css_pkg::CHAR_LF && c != css_pkg::CHAR_CR) begin
          n.content = 1'b1;
        end
        if (!st.found) begin
          if (len_eff == 4'd0) begin
            n.count = 4'd0;
          end else if (c == want) begin
            if (nc >= len_eff) begin
              n.found = 1'b1;
              n.count = 4'd0;
            end else begin
              n.count = nc;
            end
          end else begin
            n.count = 4'd0;
          end
        end
      end
    end
    return n;
  endfunction

  always_comb begin
    s = scan_cur;
    unique case (scan_cur.mode)
      css_pkg::MODE_SLASH: begin
        if (char_in == css_pkg::CHAR_STAR) begin
          s.mode = css_pkg::MODE_BLOCK;
        end else if (char_in == css_pkg::CHAR_SLASH) begin
          s.mode = css_pkg::MODE_LINE;
        end else begin
          // held slash was plain text after all
          s.mode = css_pkg::MODE_NORMAL;
          s = take(take(s, css_pkg::CHAR_SLASH), char_in);
        end
      end
      css_pkg::MODE_BLOCK: begin
        if (char_in == css_pkg::CHAR_STAR) s.mode = css_pkg::MODE_STAR;
      end
      css_pkg::MODE_STAR: begin
        if (char_in == css_pkg::CHAR_SLASH) s.mode = css_pkg::MODE_NORMAL;
        else if (char_in != css_pkg::CHAR_STAR) s.mode = css_pkg::MODE_BLOCK;
      end
      css_pkg::MODE_LINE: begin
        if (char_in == css_pkg::CHAR_LF) s.mode = css_pkg::MODE_NORMAL;
      end
      default: begin
        s.mode = css_pkg::MODE_NORMAL;
        if (char_in == css_pkg::CHAR_SLASH && !region_end) s.mode = css_pkg::MODE_SLASH;
        else s = take(s, char_in);
      end
    endcase
  end

  assign pattern_found = s.found;
  assign has_content   = s.content;
  assign scan_nxt      = region_end ? css_pkg::SCAN_CLEAR : s;

endmodule
